// ===== hdl/busp_pkg.sv =====
// Shared constants and scheme tables for the broker URI stream parser.
package busp_pkg;

    localparam int HOST_CAP_DEFAULT = 64;

    localparam int CH_W     = 8;
    localparam int PORT_W   = 16;
    localparam int PACC_W   = 17;
    localparam int HLEN_W   = 6;
    localparam int TR_W     = 2;
    localparam int POS_W    = 4;
    localparam int NSCHEME  = 4;
    localparam int OUT_TDATA_W = 40;

    localparam logic [PACC_W-1:0] PORT_BAD = 17'd65536;
    localparam logic [PACC_W-1:0] PORT_MAX = 17'd65535;

    localparam logic [CH_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CH_W-1:0] CH_QUEST = 8'h3F;
    localparam logic [CH_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

    localparam logic [TR_W-1:0] TR_TCP = 2'd0;
    localparam logic [TR_W-1:0] TR_SSL = 2'd1;
    localparam logic [TR_W-1:0] TR_WS  = 2'd2;
    localparam logic [TR_W-1:0] TR_WSS = 2'd3;

    // prefix text, one character per position
    function automatic logic [CH_W-1:0] scheme_char(input logic [TR_W-1:0] k,
                                                    input logic [2:0] pos);
        logic [63:0] txt;
        case (k)
            TR_TCP:  txt = {8'h00, "//:ttqm"};
            TR_SSL:  txt = "//:sttqm";
            TR_WS:   txt = {24'h0, "//:sw"};
            default: txt = {16'h0, "//:ssw"};
        endcase
        // txt holds the characters reversed so position 0 sits in the lowest byte
        scheme_char = txt[{pos, 3'b000} +: CH_W];
    endfunction

    function automatic logic [POS_W-1:0] scheme_len(input logic [TR_W-1:0] k);
        case (k)
            TR_TCP:  scheme_len = 4'd7;
            TR_SSL:  scheme_len = 4'd8;
            TR_WS:   scheme_len = 4'd5;
            default: scheme_len = 4'd6;
        endcase
    endfunction

    function automatic logic [PORT_W-1:0] scheme_port(input logic [TR_W-1:0] k);
        case (k)
            TR_TCP:  scheme_port = 16'd1883;
            TR_SSL:  scheme_port = 16'd8883;
            TR_WS:   scheme_port = 16'd80;
            default: scheme_port = 16'd443;
        endcase
    endfunction

    function automatic logic is_path_start(input logic [CH_W-1:0] c);
        is_path_start = (c == CH_SLASH) || (c == CH_QUEST) || (c == CH_HASH);
    endfunction

endpackage

// ===== hdl/broker_uri_stream_parser.sv =====
// Broker URI stream parser: scheme match, host collection and port decode.
// Result path: the input register captures each transfer and feeds the result register.
// Throughput: one character per cycle unless the output stalls; the parse state updates once per character.
// Each input transfer yields exactly one output transfer; tlast closes the URI.
// Reset (rst_n low, asynchronous) empties both registers and returns to scheme matching.
// The parse state also returns to scheme matching after each last character.
module broker_uri_stream_parser #(
    parameter int HOST_CAP = busp_pkg::HOST_CAP_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] host_char, [8] ok, [10:9] transport,
                                        // [26:11] port, [32:27] hname_len, rest zero
    output logic        m_axis_tuser,   // [0] host_char_valid
    output logic        m_axis_tlast
);

    localparam int HC_W = $clog2(HOST_CAP + 1);
    localparam logic [HC_W-1:0] HOST_CAP_V = HC_W'(HOST_CAP);

    localparam logic [2:0] PH_SCHEME = 3'd0;
    localparam logic [2:0] PH_HOST   = 3'd1;
    localparam logic [2:0] PH_PORT   = 3'd2;
    localparam logic [2:0] PH_PATH   = 3'd3;
    localparam logic [2:0] PH_DEAD   = 3'd4;

    logic                           in_valid_reg;
    logic [busp_pkg::CH_W-1:0]      ch_reg;
    logic                           last_reg;

    logic [2:0]                     phase_reg, phase_next;
    logic [busp_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [busp_pkg::NSCHEME-1:0]   cand_reg, cand_next;
    logic [HC_W-1:0]                hcount_reg, hcount_next;
    logic [busp_pkg::PACC_W-1:0]    port_reg, port_next;
    logic                           digits_reg, digits_next;
    logic                           failed_reg, failed_next;

    logic                           out_valid_reg;
    logic                           hv_reg, hv_next;
    logic [busp_pkg::CH_W-1:0]      hchar_reg, hchar_next;
    logic                           done_reg;
    logic                           ok_reg, ok_next;
    logic [busp_pkg::TR_W-1:0]      tr_reg, tr_next;
    logic [busp_pkg::PORT_W-1:0]    pt_reg, pt_next;
    logic [busp_pkg::HLEN_W-1:0]    hl_reg, hl_next;

    logic                           advance;
    logic                           step;
    logic [busp_pkg::NSCHEME-1:0]   keep;
    logic [busp_pkg::POS_W-1:0]     pos_inc;
    logic [3:0]                     digit;
    logic [19:0]                    pacc;
    logic                           is_digit;
    logic                           port_bad;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    assign pos_inc  = pos_reg + 1'b1;
    assign digit    = 4'(ch_reg - busp_pkg::CH_ZERO);
    assign is_digit = (ch_reg >= busp_pkg::CH_ZERO) && (ch_reg <= busp_pkg::CH_NINE);
    assign pacc     = ({3'b000, port_reg} << 3) + ({3'b000, port_reg} << 1) + 20'(digit);

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        cand_next   = cand_reg;
        hcount_next = hcount_reg;
        port_next   = port_reg;
        digits_next = digits_reg;
        failed_next = failed_reg;
        hv_next     = 1'b0;
        keep        = '0;

        for (int k = 0; k < busp_pkg::NSCHEME; k++)
        begin
            keep[k] = cand_reg[k]
                && (pos_reg < busp_pkg::scheme_len(busp_pkg::TR_W'(k)))
                && (busp_pkg::scheme_char(busp_pkg::TR_W'(k), pos_reg[2:0]) == ch_reg);
        end

        case (phase_reg)
            PH_SCHEME:
            begin
                pos_next  = pos_inc;
                cand_next = keep;
                if (keep == '0)
                begin
                    failed_next = 1'b1;
                    phase_next  = PH_DEAD;
                end
                else
                begin
                    // lowest completed scheme wins
                    for (int k = busp_pkg::NSCHEME - 1; k >= 0; k--)
                    begin
                        if (keep[k] && (pos_inc == busp_pkg::scheme_len(busp_pkg::TR_W'(k))))
                        begin
                            cand_next  = busp_pkg::NSCHEME'(1) << k;
                            phase_next = PH_HOST;
                        end
                    end
                end
            end
            PH_HOST:
            begin
                if (ch_reg == busp_pkg::CH_COLON)
                    phase_next = PH_PORT;
                else if (busp_pkg::is_path_start(ch_reg))
                    phase_next = PH_PATH;
                else
                begin
                    hv_next = 1'b1;
                    if (hcount_reg < HOST_CAP_V)
                        hcount_next = hcount_reg + 1'b1;
                end
            end
            PH_PORT:
            begin
                if (is_digit)
                begin
                    digits_next = 1'b1;
                    if (port_reg < busp_pkg::PORT_BAD)
                    begin
                        if (pacc > 20'(busp_pkg::PORT_MAX))
                            port_next = busp_pkg::PORT_BAD;
                        else
                            port_next = pacc[busp_pkg::PACC_W-1:0];
                    end
                end
                else if (busp_pkg::is_path_start(ch_reg))
                begin
                    if (!digits_reg || port_reg == '0 || port_reg > busp_pkg::PORT_MAX)
                        failed_next = 1'b1;
                    phase_next = PH_PATH;
                end
                else
                begin
                    failed_next = 1'b1;
                    phase_next  = PH_DEAD;
                end
            end
            default:
            begin
            end
        endcase

        port_bad = !digits_next || port_next == '0 || port_next > busp_pkg::PORT_MAX;

        ok_next = 1'b0;
        tr_next = '0;
        pt_next = '0;
        hl_next = '0;
        if (last_reg)
        begin
            if (!(failed_next || (phase_next == PH_PORT && port_bad))
                && (phase_next == PH_HOST || phase_next == PH_PORT || phase_next == PH_PATH)
                && hcount_next != '0 && hcount_next < HOST_CAP_V)
            begin
                ok_next = 1'b1;
                for (int k = busp_pkg::NSCHEME - 1; k >= 0; k--)
                begin
                    if (cand_next[k])
                        tr_next = busp_pkg::TR_W'(k);
                end
                pt_next = digits_next ? port_next[busp_pkg::PORT_W-1:0]
                                      : busp_pkg::scheme_port(tr_next);
                hl_next = hcount_next[busp_pkg::HLEN_W-1:0];
            end
            phase_next  = PH_SCHEME;
            pos_next    = '0;
            cand_next   = '1;
            hcount_next = '0;
            port_next   = '0;
            digits_next = 1'b0;
            failed_next = 1'b0;
        end

        hchar_next = hv_next ? ch_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_SCHEME;
            pos_reg       <= '0;
            cand_reg      <= '1;
            hcount_reg    <= '0;
            port_reg      <= '0;
            digits_reg    <= 1'b0;
            failed_reg    <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (step)
            begin
                phase_reg  <= phase_next;
                pos_reg    <= pos_next;
                cand_reg   <= cand_next;
                hcount_reg <= hcount_next;
                port_reg   <= port_next;
                digits_reg <= digits_next;
                failed_reg <= failed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            ch_reg   <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
        if (step)
        begin
            hv_reg    <= hv_next;
            hchar_reg <= hchar_next;
            done_reg  <= last_reg;
            ok_reg    <= ok_next;
            tr_reg    <= tr_next;
            pt_reg    <= pt_next;
            hl_reg    <= hl_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = hv_reg;
    assign m_axis_tlast  = done_reg;
    assign m_axis_tdata  = {7'b0, hl_reg, pt_reg, tr_reg, ok_reg, hchar_reg};

endmodule
